/* src/prb_pkg.sv */
package prb_pkg;

    localparam int P_SLOTS  = 8;
    localparam int TAG_W    = 16;
    localparam int STAMP_W  = 48;
    localparam int DEPTH_W  = 4;
    localparam int ENTRY_W  = STAMP_W + TAG_W;

    localparam logic [DEPTH_W-1:0] DEPTH_AT_RESET = 4'd4;

    typedef enum logic [1:0] {
        CMD_SUBMIT  = 2'd0,
        CMD_DECODED = 2'd1,
        CMD_FLUSH   = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYPASS,
        S_POP_RD,
        S_POP_OUT,
        S_INS_START,
        S_INS_CMP,
        S_INS_PUT
    } t_state;

    // why the front entry is being released
    typedef enum logic [1:0] {
        M_FULL,
        M_DEPTH,
        M_DRAIN
    } t_mode;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
        logic               last;
    } t_emit;

endpackage

/* src/prb_mem.sv */
module prb_mem #(
    parameter int SLOTS = prb_pkg::P_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(SLOTS)-1:0]         i_waddr,
    input  logic [prb_pkg::ENTRY_W-1:0]      i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(SLOTS)-1:0]         i_raddr,
    output logic [prb_pkg::ENTRY_W-1:0]      o_rdata
);
    import prb_pkg::*;

    logic [ENTRY_W-1:0] r_mem [SLOTS];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/prb_ctrl.sv */
module prb_ctrl #(
    parameter int SLOTS = prb_pkg::P_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_command,
    input  logic [prb_pkg::TAG_W-1:0]        i_frame_tag,
    input  logic [prb_pkg::STAMP_W-1:0]      i_presentation_stamp,
    input  logic [prb_pkg::STAMP_W-1:0]      i_decode_stamp,
    input  logic                             i_presentation_valid,
    input  logic                             i_decode_valid,
    input  logic [prb_pkg::DEPTH_W-1:0]      i_depth,
    input  logic                             i_out_ready,
    output prb_pkg::t_emit                   o_emit,
    output logic                             o_mem_we,
    output logic [$clog2(SLOTS)-1:0]         o_mem_waddr,
    output logic [prb_pkg::ENTRY_W-1:0]      o_mem_wdata,
    output logic                             o_mem_re,
    output logic [$clog2(SLOTS)-1:0]         o_mem_raddr,
    input  logic [prb_pkg::ENTRY_W-1:0]      i_mem_rdata
);
    import prb_pkg::*;

    localparam int AW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int CMPW = ((CW > DEPTH_W) ? CW : DEPTH_W) + 1;

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_j, n_j;
    logic                r_reorder_on, n_reorder_on;
    logic [TAG_W-1:0]    r_tag, n_tag;
    logic [STAMP_W-1:0]  r_pts, n_pts;

    logic                accept;
    logic [STAMP_W-1:0]  rd_stamp;
    logic [TAG_W-1:0]    rd_tag;
    logic                over_depth;

    // logical position behind the head to physical slot
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] j);
        logic [AW:0] s;
        s = (AW+1)'(head) + (AW+1)'(j);
        if (s >= (AW+1)'(SLOTS)) begin
            s = s - (AW+1)'(SLOTS);
        end
        return s[AW-1:0];
    endfunction

    assign accept     = i_valid && (r_state == S_IDLE);
    assign rd_stamp   = i_mem_rdata[ENTRY_W-1:TAG_W];
    assign rd_tag     = i_mem_rdata[TAG_W-1:0];
    assign over_depth = ((CMPW)'(r_count) + (CMPW)'(1)) > (CMPW)'(i_depth);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= M_DRAIN;
            r_head       <= '0;
            r_count      <= '0;
            r_j          <= '0;
            r_reorder_on <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_head       <= n_head;
            r_count      <= n_count;
            r_j          <= n_j;
            r_reorder_on <= n_reorder_on;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        r_pts <= n_pts;
    end

    // next state
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_head       = r_head;
        n_count      = r_count;
        n_j          = r_j;
        n_reorder_on = r_reorder_on;
        n_tag        = r_tag;
        n_pts        = r_pts;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_tag = i_frame_tag;
                    n_pts = i_presentation_stamp;
                    unique case (t_cmd'(i_command)) inside
                        CMD_SUBMIT: begin
                            if (i_presentation_valid && i_decode_valid
                                && (i_presentation_stamp != i_decode_stamp)) begin
                                n_reorder_on = 1'b1;
                            end
                        end
                        CMD_DECODED: begin
                            if (!r_reorder_on) begin
                                n_state = S_BYPASS;
                            end else if (r_count == CW'(SLOTS)) begin
                                n_mode  = M_FULL;
                                n_state = S_POP_RD;
                            end else begin
                                n_mode  = M_DEPTH;
                                n_state = S_INS_START;
                            end
                        end
                        CMD_FLUSH, CMD_RESTART: begin
                            if (t_cmd'(i_command) == CMD_RESTART) begin
                                n_reorder_on = 1'b0;
                            end
                            n_mode  = M_DRAIN;
                            n_state = (r_count == '0) ? S_IDLE : S_POP_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_BYPASS: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_POP_RD: begin
                n_state = S_POP_OUT;
            end
            S_POP_OUT: begin
                if (i_out_ready) begin
                    n_head  = (r_head == AW'(SLOTS - 1)) ? '0 : r_head + AW'(1);
                    n_count = r_count - CW'(1);
                    unique case (r_mode)
                        M_FULL:  n_state = S_INS_START;
                        M_DEPTH: n_state = S_IDLE;
                        M_DRAIN: n_state = (r_count == CW'(1)) ? S_IDLE : S_POP_RD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_START: begin
                n_j     = r_count;
                n_state = (r_count == '0) ? S_INS_PUT : S_INS_CMP;
            end
            S_INS_CMP: begin
                // read data holds the entry just before position j
                if (r_pts < rd_stamp) begin
                    n_j     = r_j - CW'(1);
                    n_state = (r_j == CW'(1)) ? S_INS_PUT : S_INS_CMP;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                n_count = r_count + CW'(1);
                if ((r_mode == M_DEPTH) && over_depth) begin
                    n_state = S_POP_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stall     = (r_state != S_IDLE);
        o_mem_we    = 1'b0;
        o_mem_waddr = phys(r_head, r_j);
        o_mem_wdata = {r_pts, r_tag};
        o_mem_re    = 1'b0;
        o_mem_raddr = r_head;
        o_emit      = '{valid: 1'b0, tag: r_tag, stamp: r_pts, last: 1'b1};
        unique case (r_state)
            S_IDLE: ;
            S_BYPASS: begin
                o_emit.valid = 1'b1;
            end
            S_POP_RD: begin
                o_mem_re = 1'b1;
            end
            S_POP_OUT: begin
                o_emit.valid = 1'b1;
                o_emit.tag   = rd_tag;
                o_emit.stamp = rd_stamp;
                o_emit.last  = (r_mode != M_DRAIN) || (r_count == CW'(1));
            end
            S_INS_START: begin
                o_mem_re    = (r_count != '0);
                o_mem_raddr = phys(r_head, r_count - CW'(1));
            end
            S_INS_CMP: begin
                if (r_pts < rd_stamp) begin
                    // shift the older entry one place back, fetch the next one
                    o_mem_we    = 1'b1;
                    o_mem_wdata = i_mem_rdata;
                    o_mem_re    = (r_j != CW'(1));
                    o_mem_raddr = phys(r_head, r_j - CW'(2));
                end
            end
            S_INS_PUT: begin
                o_mem_we = 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("entry count above store size");

    a_off_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_reorder_on) |-> (r_count == '0))
        else $error("entries held while reordering is off");

    a_full_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_PUT && r_mode == M_FULL) |-> (r_count == CW'(SLOTS - 1)))
        else $error("insert after full release without a free slot");

    a_walk_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_CMP) |-> (r_j != '0))
        else $error("insert walk past the front");
`endif

endmodule

/* src/pts_reorder_buffer.sv */
// channel   direction  handshake             payload
// input     in         i_valid / o_stall     i_command, i_frame_tag, i_presentation_stamp,
//                                            i_decode_stamp, i_presentation_valid,
//                                            i_decode_valid
// output    out        o_valid / i_stall     o_out_tag, o_out_stamp, o_last_of_run
// config    in         i_cfg_we              i_cfg_data
//
// one beat at a time: a submit is taken while idle, a pass-through frame goes out through
// the bypass state, a sorted insert of a frame walks back from the last entry held to its place
// (one slot read per cycle from the store memory), and a released entry is read and then output.
// flush and restart release entries one at a time, each read from the registered store memory and then output.
// synchronous active-low reset empties the store; no clearing pass is needed.
// a stall on the output holds the block in its current release until the beat is taken.
module pts_reorder_buffer #(
    parameter int SLOTS = prb_pkg::P_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_command,
    input  logic [prb_pkg::TAG_W-1:0]        i_frame_tag,
    input  logic [prb_pkg::STAMP_W-1:0]      i_presentation_stamp,
    input  logic [prb_pkg::STAMP_W-1:0]      i_decode_stamp,
    input  logic                             i_presentation_valid,
    input  logic                             i_decode_valid,
    input  logic                             i_cfg_we,
    input  logic [prb_pkg::DEPTH_W-1:0]      i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [prb_pkg::TAG_W-1:0]        o_out_tag,
    output logic [prb_pkg::STAMP_W-1:0]      o_out_stamp,
    output logic                             o_last_of_run
);
    import prb_pkg::*;

    localparam int AW = $clog2(SLOTS);

    logic [DEPTH_W-1:0]  r_depth;
    logic                r_out_valid;
    logic [TAG_W-1:0]    r_out_tag;
    logic [STAMP_W-1:0]  r_out_stamp;
    logic                r_out_last;

    t_emit               emit;
    logic                out_ready;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_AT_RESET;
        end else if (i_cfg_we) begin
            r_depth <= i_cfg_data;
        end
    end

    // output register frees up in the same cycle its beat is taken
    assign out_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && emit.valid) begin
            r_out_tag   <= emit.tag;
            r_out_stamp <= emit.stamp;
            r_out_last  <= emit.last;
        end
    end

    prb_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_command            (i_command),
        .i_frame_tag          (i_frame_tag),
        .i_presentation_stamp (i_presentation_stamp),
        .i_decode_stamp       (i_decode_stamp),
        .i_presentation_valid (i_presentation_valid),
        .i_decode_valid       (i_decode_valid),
        .i_depth              (r_depth),
        .i_out_ready          (out_ready),
        .o_emit               (emit),
        .o_mem_we             (mem_we),
        .o_mem_waddr          (mem_waddr),
        .o_mem_wdata          (mem_wdata),
        .o_mem_re             (mem_re),
        .o_mem_raddr          (mem_raddr),
        .i_mem_rdata          (mem_rdata)
    );

    prb_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_valid       = r_out_valid;
    assign o_out_tag     = r_out_tag;
    assign o_out_stamp   = r_out_stamp;
    assign o_last_of_run = r_out_last;

endmodule
